### hw/rtl/bsbp_pkg.sv
package bsbp_pkg;

    localparam int COLOR_BITS = 24;
    localparam int PIXEL_W    = 24;
    localparam int WORD_W     = 32;
    localparam int MODE_W     = 2;
    localparam int DIM_W      = 9;
    localparam int TOTAL_W    = 2 * DIM_W;
    localparam int HEAD_FIX   = MODE_W + 2 * DIM_W;
    localparam int CNT_MAX    = 17;
    localparam int HEAD_MAX   = HEAD_FIX + CNT_MAX;
    localparam int PIX_MAX    = COLOR_BITS + 1;
    localparam int ACC_W      = WORD_W - 1;
    localparam int PEND_W     = $clog2(WORD_W);
    localparam int STREAM_W   = ACC_W + HEAD_MAX + PIX_MAX;
    localparam int LEN_W      = $clog2(STREAM_W + 1);
    localparam int PROD_W     = TOTAL_W + $clog2(PIX_MAX + 1);
    localparam int SUM_W      = PROD_W + 1;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = DIM_W;
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd2;

    // pixel modes
    localparam logic [MODE_W-1:0] MODE_MONO    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MONO_T  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COLOR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COLOR_T = 2'd3;

    localparam int CNT_BITS_MONO   = 12;
    localparam int CNT_BITS_MONO_T = 13;
    localparam int CNT_BITS_COLOR  = 17;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [TOTAL_W-1:0]  total;
        logic [HEAD_MAX-1:0] head;
        logic [LEN_W-1:0]    head_len;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_word;

    typedef struct packed {
        logic [1:0] count;
        t_word      w0;
        t_word      w1;
    } t_push;

    function automatic logic [LEN_W-1:0] cnt_bits(input logic [MODE_W-1:0] m);
        logic [LEN_W-1:0] r;
        case (m)
            MODE_MONO:    r = LEN_W'(CNT_BITS_MONO);
            MODE_MONO_T:  r = LEN_W'(CNT_BITS_MONO_T);
            MODE_COLOR:   r = LEN_W'(CNT_BITS_COLOR);
            MODE_COLOR_T: r = LEN_W'(CNT_BITS_COLOR);
            default:      r = LEN_W'(CNT_BITS_COLOR);
        endcase
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] pix_bits(input logic [MODE_W-1:0] m);
        logic [LEN_W-1:0] r;
        r = m[1] ? LEN_W'(COLOR_BITS) : LEN_W'(1);
        return r + LEN_W'(m[0]);
    endfunction

endpackage

### hw/rtl/bsbp_cfg.sv
module bsbp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsbp_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bsbp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output bsbp_pkg::t_cfg                    o_cfg
);

    logic [bsbp_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [bsbp_pkg::DIM_W-1:0]  r_width, n_width;
    logic [bsbp_pkg::DIM_W-1:0]  r_height, n_height;
    bsbp_pkg::t_cfg              r_cfg, n_cfg;

    logic [bsbp_pkg::TOTAL_W-1:0]  total;
    logic [bsbp_pkg::PROD_W-1:0]   prod;
    logic [bsbp_pkg::SUM_W-1:0]    sum;
    logic [bsbp_pkg::LEN_W-1:0]    cbits;
    logic [bsbp_pkg::HEAD_MAX-1:0] cnt_mask;

    always_comb begin
        n_mode   = r_mode;
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                bsbp_pkg::REG_MODE:   n_mode   = i_cfg_wdata[bsbp_pkg::MODE_W-1:0];
                bsbp_pkg::REG_WIDTH:  n_width  = i_cfg_wdata[bsbp_pkg::DIM_W-1:0];
                bsbp_pkg::REG_HEIGHT: n_height = i_cfg_wdata[bsbp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // derived header fields follow the next register values, so they line up
    // with the registers themselves
    always_comb begin
        total = n_width * n_height;
        prod  = n_mode[1] ? bsbp_pkg::PROD_W'(total) * bsbp_pkg::PROD_W'(bsbp_pkg::COLOR_BITS)
                          : bsbp_pkg::PROD_W'(total);
        if (n_mode[0]) begin
            prod = prod + bsbp_pkg::PROD_W'(total);
        end
        cbits = bsbp_pkg::cnt_bits(n_mode);
        // round up to whole words, header included
        sum   = bsbp_pkg::SUM_W'(prod) + bsbp_pkg::SUM_W'(bsbp_pkg::HEAD_FIX + bsbp_pkg::WORD_W - 1)
              + bsbp_pkg::SUM_W'(cbits);
        cnt_mask = ~({bsbp_pkg::HEAD_MAX{1'b1}} << cbits);

        n_cfg.mode     = n_mode;
        n_cfg.total    = total;
        n_cfg.head     = (bsbp_pkg::HEAD_MAX'({n_mode, n_width, n_height}) << cbits)
                       | (bsbp_pkg::HEAD_MAX'(sum >> 5) & cnt_mask);
        n_cfg.head_len = bsbp_pkg::LEN_W'(bsbp_pkg::HEAD_FIX) + cbits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_cfg    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_width  <= n_width;
            r_height <= n_height;
            r_cfg    <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/bsbp_core.sv
module bsbp_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsbp_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bsbp_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic                           i_transparent,
    input  logic                           i_space_ok,
    output bsbp_pkg::t_push                o_push
);

    logic                          r_in_valid, n_in_valid;
    logic [bsbp_pkg::PIXEL_W-1:0]  r_pixel;
    logic                          r_transp;

    logic [bsbp_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic [bsbp_pkg::PEND_W-1:0]   r_pend, n_pend;
    logic [bsbp_pkg::TOTAL_W-1:0]  r_seen, n_seen;
    logic                          r_hdr_sent, n_hdr_sent;

    logic                          accept;
    logic                          fire;
    logic                          active;
    logic                          last_img;
    logic [bsbp_pkg::TOTAL_W-1:0]  seen_inc;
    logic [bsbp_pkg::LEN_W-1:0]    pb;
    logic [bsbp_pkg::LEN_W-1:0]    hl;
    logic [bsbp_pkg::LEN_W-1:0]    len;
    logic [bsbp_pkg::LEN_W-1:0]    rest;
    logic [1:0]                    nfull;
    logic [1:0]                    nout;
    logic [bsbp_pkg::PIX_MAX-1:0]  pix;
    logic [bsbp_pkg::STREAM_W-1:0] s;
    logic [bsbp_pkg::STREAM_W-1:0] sh;

    assign fire    = r_in_valid && i_space_ok;
    assign o_ready = !r_in_valid || i_space_ok;
    assign accept  = i_valid && o_ready;
    assign active  = fire && (i_cfg.total != '0);

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        pb  = bsbp_pkg::pix_bits(i_cfg.mode);
        pix = i_cfg.mode[1]
            ? (bsbp_pkg::PIX_MAX'(r_pixel) & ~({bsbp_pkg::PIX_MAX{1'b1}} << bsbp_pkg::COLOR_BITS))
            : bsbp_pkg::PIX_MAX'(r_pixel[0]);
        if (i_cfg.mode[0]) begin
            pix = pix | (bsbp_pkg::PIX_MAX'(r_transp) << (pb - 1'b1));
        end

        // pending bits, then header on the first pixel, then the pixel
        s  = bsbp_pkg::STREAM_W'(r_acc);
        hl = '0;
        if (!r_hdr_sent) begin
            s  = (s << i_cfg.head_len) | bsbp_pkg::STREAM_W'(i_cfg.head);
            hl = i_cfg.head_len;
        end
        s   = (s << pb) | bsbp_pkg::STREAM_W'(pix);
        len = bsbp_pkg::LEN_W'(r_pend) + hl + pb;

        // left-align so words come from the top
        sh = s << (bsbp_pkg::LEN_W'(bsbp_pkg::STREAM_W) - len);

        if (len >= bsbp_pkg::LEN_W'(2 * bsbp_pkg::WORD_W)) begin
            nfull = 2'd2;
        end else if (len >= bsbp_pkg::LEN_W'(bsbp_pkg::WORD_W)) begin
            nfull = 2'd1;
        end else begin
            nfull = 2'd0;
        end
        rest = len - bsbp_pkg::LEN_W'({nfull, 5'b0});

        seen_inc = r_seen + 1'b1;
        last_img = seen_inc >= i_cfg.total;

        // padded tail only if a slot is left
        nout = nfull;
        if (last_img && nfull != 2'd2 && rest != '0) begin
            nout = nfull + 1'b1;
        end
    end

    always_comb begin
        n_acc      = r_acc;
        n_pend     = r_pend;
        n_seen     = r_seen;
        n_hdr_sent = r_hdr_sent;
        if (active) begin
            if (last_img) begin
                n_acc      = '0;
                n_pend     = '0;
                n_seen     = '0;
                n_hdr_sent = 1'b0;
            end else begin
                n_acc      = s[bsbp_pkg::ACC_W-1:0]
                           & ~({bsbp_pkg::ACC_W{1'b1}} << rest[bsbp_pkg::PEND_W-1:0]);
                n_pend     = rest[bsbp_pkg::PEND_W-1:0];
                n_seen     = seen_inc;
                n_hdr_sent = 1'b1;
            end
        end
    end

    always_comb begin
        o_push.count   = active ? nout : 2'd0;
        o_push.w0.word = sh[bsbp_pkg::STREAM_W-1 -: bsbp_pkg::WORD_W];
        o_push.w0.last = last_img && (nout == 2'd1);
        o_push.w1.word = sh[bsbp_pkg::STREAM_W-1-bsbp_pkg::WORD_W -: bsbp_pkg::WORD_W];
        o_push.w1.last = last_img && (nout == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_acc      <= '0;
            r_pend     <= '0;
            r_seen     <= '0;
            r_hdr_sent <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_acc      <= n_acc;
            r_pend     <= n_pend;
            r_seen     <= n_seen;
            r_hdr_sent <= n_hdr_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel  <= i_pixel;
            r_transp <= i_transparent;
        end
    end

endmodule

### hw/rtl/bsbp_ofifo.sv
module bsbp_ofifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bsbp_pkg::t_push             i_push,
    output logic                        o_space_ok,
    output logic                        o_valid,
    input  logic                        i_ready,
    output bsbp_pkg::t_word             o_word
);

    bsbp_pkg::t_word                   r_mem [bsbp_pkg::OFIFO_DEPTH];
    logic [bsbp_pkg::OFIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [bsbp_pkg::OFIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [bsbp_pkg::OFIFO_CNT_W-1:0]  r_cnt, n_cnt;
    logic [bsbp_pkg::OFIFO_PTR_W-1:0]  wr_ptr_p1;
    logic                              pop;

    assign o_valid    = r_cnt != '0;
    assign pop        = o_valid && i_ready;
    // room for the largest burst a single transaction can push
    assign o_space_ok = r_cnt <= bsbp_pkg::OFIFO_CNT_W'(bsbp_pkg::OFIFO_DEPTH - 2);
    assign wr_ptr_p1  = r_wr_ptr + 1'b1;
    assign o_word     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + bsbp_pkg::OFIFO_PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + bsbp_pkg::OFIFO_PTR_W'(pop);
        n_cnt    = r_cnt + bsbp_pkg::OFIFO_CNT_W'(i_push.count)
                 - bsbp_pkg::OFIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.w0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push.w1;
        end
    end

endmodule

### hw/rtl/bitmap_sprite_bit_packer.sv
// Bitmap packer: turns a raster-order pixel stream into MSB-first 32-bit words.
// Configure mode, width and height through the write port while idle; the
// header fields derived from them are registered at the same edge as the write.
// Slave stream: one pixel per transaction, tdata = pixel value, tuser = the
// transparency bit. Master stream: one packed word per transaction, tlast on
// the final zero-padded word of the image. The header words go out ahead of
// the first pixel's bits; an image of zero pixels swallows its input.
// A pixel accepted into the input register goes through the pack stage, which
// writes its words into the output queue once the queue has room; the master
// side takes them from the head of the queue.
// Throughput: one pixel per cycle while the output queue has room, set by the
// combinational pack stage; the last pixel of an image can push two words,
// which the 4-entry output queue absorbs and drains at one word per cycle.
// A stalled receiver fills the output queue; the pack stage holds its pixel
// once fewer than two entries are free, and tready then drops.
// Reset (synchronous, active low) clears the configuration registers, the
// partial word and the image position, and empties the output queue.
module bitmap_sprite_bit_packer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [bsbp_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [bsbp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [bsbp_pkg::PIXEL_W-1:0]         i_s_axis_tdata,  // [23:0] pixel_value
    input  logic                                 i_s_axis_tuser,  // [0] transparent
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [bsbp_pkg::WORD_W-1:0]          o_m_axis_tdata,  // [31:0] word
    output logic                                 o_m_axis_tlast
);

    bsbp_pkg::t_cfg  cfg;
    bsbp_pkg::t_push push;
    bsbp_pkg::t_word out_word;
    logic            space_ok;

    bsbp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bsbp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_pixel       (i_s_axis_tdata),
        .i_transparent (i_s_axis_tuser),
        .i_space_ok    (space_ok),
        .o_push        (push)
    );

    bsbp_ofifo u_ofifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_space_ok (space_ok),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_word     (out_word)
    );

    assign o_m_axis_tdata = out_word.word;
    assign o_m_axis_tlast = out_word.last;

endmodule
